FILE: rtl/skpi_pkg.sv
// ----------------------------------------------------------------------------
// skpi_pkg: types and codes for the sorted key position index unit
// Command and result layouts, opcodes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package skpi_pkg;

  localparam int unsigned PosBits   = 16;
  localparam int unsigned KeyInBits = 16;
  localparam int unsigned CountBits = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_INS_SCAN,
    SQ_INS_WRITE,
    SQ_FIND,
    SQ_REM_SHIFT
  } seq_state_e;

  typedef struct packed {
    op_e                  opcode;
    logic [KeyInBits-1:0] key;
    logic [PosBits-1:0]   position;
  } cmd_t;

  typedef struct packed {
    logic                 found;
    logic [PosBits-1:0]   position_out;
    status_e              status;
    logic [CountBits-1:0] entry_count;
  } result_t;

endpackage

FILE: rtl/sorted_key_position_index_unit.sv
// ----------------------------------------------------------------------------
// sorted_key_position_index_unit: bounded sorted key/position table
// Holds up to CAPACITY key/position pairs in ascending key order in one
// memory, and serves insert, lookup, remove and clear one command at a time.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake        payload
//  command  in   start & !busy    cmd_i    (opcode, key, position)
//  result   out  done_o, 1 cycle  result_o (found, position_out, status, entry_count)
//
//  One read port and one entry visited per cycle, so the time from start transfer
//  to done_o grows with the N entries held for insert, lookup and remove; clear
//  does not walk the table. busy is high while the sequencer walks the table; a
//  new command can be taken in the cycle done_o is high.
//  Reset clears the entry count and the sequencer; memory contents are kept,
//  since only entries below the count are ever read. The receiver cannot stall.
//
module sorted_key_position_index_unit #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned KEY_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  skpi_pkg::cmd_t    cmd_i,
  output logic              done_o,
  output skpi_pkg::result_t result_o
);

  import skpi_pkg::*;

  localparam int unsigned IdxBits   = $clog2(CAPACITY);
  localparam int unsigned CntBits   = $clog2(CAPACITY + 1);
  localparam int unsigned EntryBits = KEY_BITS + PosBits;

  // Table memory: key in the upper bits, position in the lower bits.
  logic [EntryBits-1:0] mem_q [CAPACITY];
  logic [EntryBits-1:0] rd_data_q;
  logic                 mem_we;
  logic [IdxBits-1:0]   mem_wa;
  logic [EntryBits-1:0] mem_wd;
  logic [IdxBits-1:0]   rd_addr;

  seq_state_e           state_q, state_d;
  logic [CntBits-1:0]   fill_q, fill_d;
  logic [IdxBits-1:0]   idx_q, idx_d;
  logic [IdxBits-1:0]   at_q, at_d;
  logic                 done_q, done_d;
  result_t              res_q, res_d;

  // Latched command
  op_e                  op_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [PosBits-1:0]   pos_q;

  logic                 accept;
  logic [KEY_BITS-1:0]  key_in;
  logic [KEY_BITS-1:0]  rd_key;
  logic [PosBits-1:0]   rd_pos;
  logic                 is_last;
  logic                 shift_up;

  assign accept = start && !busy;
  // Key is taken modulo 2^KEY_BITS (zero-extended when wider than the field).
  assign key_in = KEY_BITS'(cmd_i.key);
  assign rd_key = rd_data_q[EntryBits-1:PosBits];
  assign rd_pos = rd_data_q[PosBits-1:0];

  // Entry idx_q is the last one held.
  assign is_last = (CntBits'(idx_q) + CntBits'(1)) == fill_q;

  // Downward insert scan: entries at or above the slot move up one place.
  // The head only moves for a strictly greater key, so an equal head key
  // keeps its place and the new pair lands right after it.
  assign shift_up = (idx_q == '0) ? (rd_key > key_q) : (rd_key >= key_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= cmd_i.opcode;
      key_q <= key_in;
      pos_q <= cmd_i.position;
    end
    idx_q <= idx_d;
    at_q  <= at_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      fill_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    idx_d   = idx_q;
    at_d    = at_q;
    done_d  = 1'b0;
    res_d   = res_q;
    mem_we  = 1'b0;
    mem_wa  = idx_q;
    mem_wd  = rd_data_q;
    rd_addr = idx_q;

    case (state_q)
      SQ_IDLE: begin
        if (accept) begin
          res_d.found        = 1'b0;
          res_d.position_out = '0;
          res_d.status       = ST_DONE;
          res_d.entry_count  = CountBits'(fill_q);
          case (cmd_i.opcode)
            OP_INSERT: begin
              if (fill_q == CntBits'(CAPACITY)) begin
                res_d.status = ST_FULL;
                done_d       = 1'b1;
              end else if (fill_q == '0) begin
                at_d    = '0;
                state_d = SQ_INS_WRITE;
              end else begin
                rd_addr = IdxBits'(fill_q - CntBits'(1));
                idx_d   = rd_addr;
                state_d = SQ_INS_SCAN;
              end
            end
            OP_LOOKUP, OP_REMOVE: begin
              if (fill_q == '0) begin
                res_d.status = ST_NOT_FOUND;
                done_d       = 1'b1;
              end else begin
                rd_addr = '0;
                idx_d   = '0;
                state_d = SQ_FIND;
              end
            end
            default: begin
              // clear
              fill_d            = '0;
              res_d.entry_count = '0;
              done_d            = 1'b1;
            end
          endcase
        end
      end

      SQ_INS_SCAN: begin
        if (shift_up) begin
          mem_we = 1'b1;
          mem_wa = idx_q + IdxBits'(1);
          mem_wd = rd_data_q;
          if (idx_q == '0) begin
            at_d    = '0;
            state_d = SQ_INS_WRITE;
          end else begin
            rd_addr = idx_q - IdxBits'(1);
            idx_d   = rd_addr;
          end
        end else begin
          at_d    = idx_q + IdxBits'(1);
          state_d = SQ_INS_WRITE;
        end
      end

      SQ_INS_WRITE: begin
        mem_we            = 1'b1;
        mem_wa            = at_q;
        mem_wd            = {key_q, pos_q};
        fill_d            = fill_q + CntBits'(1);
        res_d.entry_count = CountBits'(fill_d);
        done_d            = 1'b1;
        state_d           = SQ_IDLE;
      end

      SQ_FIND: begin
        if (rd_key == key_q) begin
          res_d.found = 1'b1;
          if (op_q == OP_LOOKUP) begin
            res_d.position_out = rd_pos;
            done_d             = 1'b1;
            state_d            = SQ_IDLE;
          end else if (is_last) begin
            fill_d            = fill_q - CntBits'(1);
            res_d.entry_count = CountBits'(fill_d);
            done_d            = 1'b1;
            state_d           = SQ_IDLE;
          end else begin
            rd_addr = idx_q + IdxBits'(1);
            idx_d   = rd_addr;
            state_d = SQ_REM_SHIFT;
          end
        end else if (is_last) begin
          res_d.status = ST_NOT_FOUND;
          done_d       = 1'b1;
          state_d      = SQ_IDLE;
        end else begin
          rd_addr = idx_q + IdxBits'(1);
          idx_d   = rd_addr;
        end
      end

      SQ_REM_SHIFT: begin
        // close the gap: entry idx_q moves down one place
        mem_we = 1'b1;
        mem_wa = idx_q - IdxBits'(1);
        mem_wd = rd_data_q;
        if (is_last) begin
          fill_d            = fill_q - CntBits'(1);
          res_d.entry_count = CountBits'(fill_d);
          done_d            = 1'b1;
          state_d           = SQ_IDLE;
        end else begin
          rd_addr = idx_q + IdxBits'(1);
          idx_d   = rd_addr;
        end
      end

      default: begin
        state_d = SQ_IDLE;
      end
    endcase
  end

  assign busy     = (state_q != SQ_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

FILE: tb/sv/sorted_key_position_index_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_position_index_unit_tb: self-checking regression
// Drives insert, lookup, remove and clear commands through the start/busy
// handshake. A behavioral copy of the sorted table predicts every result, and
// a checker compares each done_o transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_key_position_index_unit_tb;
  import skpi_pkg::*;

  localparam int Capacity      = 16;
  localparam int WatchdogLimit = 2000;  // cycles with no transfer at all
  localparam int SettleCycles  = 24;    // covers the longest command, an insert into a nearly full table
  localparam int MaxPrinted    = 40;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  cmd_t    cmd_i;
  logic    done_o;
  result_t result_o;

  sorted_key_position_index_unit #(
    .CAPACITY(Capacity),
    .KEY_BITS(16)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // Shadow copy of the table, kept in ascending key order.
  logic [15:0] idx_key [Capacity];
  logic [15:0] idx_pos [Capacity];
  int          idx_fill;

  // Results predicted for accepted commands, oldest first.
  result_t     pending_results[$];

  // Keys reused often so lookups and removes hit and duplicates pile up.
  logic [15:0] key_pool [8];

  int idle_pct;
  int mismatch_count;
  int stall_cycles;
  int items_sent;
  int results_checked;
  int full_refusals;
  int match_hits;
  int misses;

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Table predictor
  // --------------------------------------------------------------------------

  // First entry with an equal key, or idx_fill when there is none.
  function automatic int first_key_match(input logic [15:0] k);
    for (int i = 0; i < idx_fill; i++) begin
      if (idx_key[i] == k) return i;
    end
    return idx_fill;
  endfunction

  // Applies one command to the shadow table and returns the result it yields.
  function automatic result_t apply_index_op(input cmd_t c);
    result_t r;
    int      at;
    r = '0;
    case (c.opcode)
      OP_INSERT: begin
        if (idx_fill >= Capacity) begin
          r.status = ST_FULL;
        end else begin
          // Head placement rule: a key equal to the head lands right after it.
          if (idx_fill == 0 || idx_key[0] > c.key) begin
            at = 0;
          end else begin
            at = 1;
            while (at < idx_fill && idx_key[at] < c.key) at++;
          end
          for (int i = idx_fill; i > at; i--) begin
            idx_key[i] = idx_key[i-1];
            idx_pos[i] = idx_pos[i-1];
          end
          idx_key[at] = c.key;
          idx_pos[at] = c.position;
          idx_fill++;
        end
      end
      OP_LOOKUP: begin
        at = first_key_match(c.key);
        if (at < idx_fill) begin
          r.found        = 1'b1;
          r.position_out = idx_pos[at];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      OP_REMOVE: begin
        at = first_key_match(c.key);
        if (at < idx_fill) begin
          r.found = 1'b1;
          for (int i = at; i + 1 < idx_fill; i++) begin
            idx_key[i] = idx_key[i+1];
            idx_pos[i] = idx_pos[i+1];
          end
          idx_fill--;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      default: begin
        idx_fill = 0;
      end
    endcase
    r.entry_count = idx_fill[4:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------

  function automatic cmd_t mk_cmd(input op_e op, input logic [15:0] k,
                                  input logic [15:0] p);
    cmd_t c;
    c.opcode   = op;
    c.key      = k;
    c.position = p;
    return c;
  endfunction

  // One command transfer. start stays high afterwards so the next command can
  // go back to back; whoever pauses next drops it at the following falling edge.
  task automatic send_cmd(input cmd_t c);
    result_t r;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    r = apply_index_op(c);
    pending_results.push_back(r);
    items_sent++;
    if (r.status == ST_FULL) full_refusals++;
    if (r.status == ST_NOT_FOUND) misses++;
    if (r.found) match_hits++;
  endtask

  // Hold off new commands until every outstanding result is back.
  task automatic wait_drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_key();
    int r;
    r = $urandom_range(9);
    if (r < 4 && idx_fill > 0) return idx_key[$urandom_range(idx_fill - 1)];
    if (r < 9) return key_pool[$urandom_range(7)];
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_position();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: the receiver cannot stall, so every done_o cycle is a
  // transfer and is matched against the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    if (mismatch_count < MaxPrinted) $display("[%0t] MISMATCH %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with no command outstanding");
      end else begin
        exp_r = pending_results.pop_front();
        results_checked++;
        if (result_o.found !== exp_r.found)
          report_mismatch($sformatf("found got %0b want %0b",
                                    result_o.found, exp_r.found));
        if (result_o.position_out !== exp_r.position_out)
          report_mismatch($sformatf("position_out got %h want %h",
                                    result_o.position_out, exp_r.position_out));
        if (result_o.status !== exp_r.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    result_o.status, exp_r.status));
        if (result_o.entry_count !== exp_r.entry_count)
          report_mismatch($sformatf("entry_count got %0d want %0d",
                                    result_o.entry_count, exp_r.entry_count));
      end
    end
  end

  // Watchdog: a hung handshake shows up as a long run with no transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WatchdogLimit) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $time, stall_cycles);
        $display("sorted_key_position_index_unit regression: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every miss path on an empty table, and a clear with nothing held.
  task automatic test_empty_table();
    send_cmd(mk_cmd(OP_LOOKUP, 16'h0000, 16'hFFFF));
    send_cmd(mk_cmd(OP_REMOVE, 16'hFFFF, 16'h0000));
    send_cmd(mk_cmd(OP_CLEAR,  16'hA5A5, 16'h5A5A));
  endtask

  // New head, duplicate of the head going right after it, and first-match
  // semantics of lookup and remove.
  task automatic test_head_placement();
    send_cmd(mk_cmd(OP_INSERT, 16'hFFFF, 16'hFFFF));
    send_cmd(mk_cmd(OP_INSERT, 16'h0000, 16'h0000));
    send_cmd(mk_cmd(OP_INSERT, 16'h0000, 16'h0001));
    send_cmd(mk_cmd(OP_LOOKUP, 16'h0000, 16'h0000));
    send_cmd(mk_cmd(OP_REMOVE, 16'h0000, 16'h0000));
    send_cmd(mk_cmd(OP_LOOKUP, 16'h0000, 16'h0000));
  endtask

  // Fill to capacity with each key landing at the head, hit the refusal, clear.
  task automatic test_full_table();
    int n;
    n = 0;
    while (idx_fill < Capacity) begin
      send_cmd(mk_cmd(OP_INSERT, 16'hF000 - 16'(n * 16'h1000), 16'(n)));
      n++;
    end
    send_cmd(mk_cmd(OP_INSERT, 16'h0000, 16'hBEEF));
    send_cmd(mk_cmd(OP_CLEAR,  16'h0000, 16'h0000));
  endtask

  // Explicit hold-off: duplicates queued, then the sender waits for all results.
  task automatic test_drain_pause();
    idle_pct = 0;
    for (int i = 0; i < 4; i++) send_cmd(mk_cmd(OP_INSERT, key_pool[2], pick_position()));
    wait_drain();
    send_cmd(mk_cmd(OP_LOOKUP, key_pool[2], 16'h0000));
    send_cmd(mk_cmd(OP_REMOVE, key_pool[2], 16'h0000));
    wait_drain();
  endtask

  // Mostly well-formed traffic: fill toward capacity, then drain with lookups
  // and removes of held keys. A slice of uniform noise is mixed in.
  task automatic test_random_traffic(input int n_items, input int pct);
    bit          filling;
    int          roll;
    op_e         op;
    logic [15:0] k;
    idle_pct = pct;
    filling  = 1'b1;
    for (int n = 0; n < n_items; n++) begin
      if (idx_fill == Capacity && $urandom_range(3) == 0) filling = 1'b0;
      else if (idx_fill == 0) filling = 1'b1;
      roll = $urandom_range(99);
      if (roll < 12) op = op_e'($urandom_range(3));
      else if (filling)
        op = (roll < 82) ? OP_INSERT : (roll < 91) ? OP_LOOKUP :
             (roll < 99) ? OP_REMOVE : OP_CLEAR;
      else
        op = (roll < 25) ? OP_INSERT : (roll < 55) ? OP_LOOKUP :
             (roll < 99) ? OP_REMOVE : OP_CLEAR;
      k = (roll < 12) ? 16'($urandom) : pick_key();
      send_cmd(mk_cmd(op, k, pick_position()));
      if ($urandom_range(39) == 0) wait_drain();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    cmd_i           = '0;
    idle_pct        = 0;
    idx_fill        = 0;
    mismatch_count  = 0;
    stall_cycles    = 0;
    items_sent      = 0;
    results_checked = 0;
    full_refusals   = 0;
    match_hits      = 0;
    misses          = 0;
    key_pool[0]     = 16'h0000;
    key_pool[1]     = 16'hFFFF;
    for (int i = 2; i < 8; i++) key_pool[i] = 16'($urandom);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_table();
    test_head_placement();
    test_full_table();
    test_drain_pause();
    test_random_traffic(340, 0);
    test_random_traffic(340, 70);
    test_random_traffic(340, 33);

    wait_drain();
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d commands, %0d results checked", items_sent, results_checked);
    $display("refused inserts %0d, matches %0d, misses %0d, mismatches %0d",
             full_refusals, match_hits, misses, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("sorted_key_position_index_unit regression: pass");
    end else begin
      $display("sorted_key_position_index_unit regression: fail");
    end
    $finish;
  end

endmodule
